/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear map package
// Sizes, types and helper functions shared by the map core and its divider.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int TABLE_COUNT = 2;

    localparam int COORD_W  = 16;
    localparam int OUT_W    = 8;
    localparam int CNT_W    = 4;
    localparam int PIDX_W   = 3;
    localparam int IDX_W    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int TBL_W    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int DEPTH    = TABLE_COUNT * MAX_POINTS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ENTRY_W  = COORD_W + OUT_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int NUM_W    = OUT_W + 1 + DIFF_W;
    localparam int MAG_W    = NUM_W - 2;
    localparam int DEN_W    = COORD_W;
    localparam int VAL_W    = NUM_W + 1;

    localparam logic [CNT_W-1:0] POINT_COUNT_RESET = CNT_W'(8);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TBL_W-1:0]  t_tbl;
    typedef logic [ADDR_W-1:0] t_addr;

    function automatic t_tbl table_of(input logic sel);
        if (TABLE_COUNT > 1) begin
            return TBL_W'(sel);
        end
        return '0;
    endfunction

    function automatic t_addr mem_addr(input t_tbl tbl, input t_idx idx);
        return ADDR_W'(ADDR_W'(tbl) * ADDR_W'(MAX_POINTS)) + ADDR_W'(idx);
    endfunction

    function automatic t_idx last_index(input logic [CNT_W-1:0] cnt);
        int n;
        n = int'(cnt);
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_POINTS) begin
            n = MAX_POINTS;
        end
        return IDX_W'(n - 1);
    endfunction

    function automatic logic adjacent(input t_idx lo, input t_idx hi);
        return ({1'b0, lo} + (IDX_W + 1)'(1)) == {1'b0, hi};
    endfunction

endpackage

/* rtl/core/ple_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear map divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ple_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ple_pkg::MAG_W-1:0] i_dividend,
    input  logic [ple_pkg::DEN_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [ple_pkg::MAG_W-1:0] o_quotient
);
    import ple_pkg::*;

    localparam int CNT_BITS = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]    r_quo;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_W:0]      w_shift;
    logic [DEN_W:0]      w_sub;
    logic                w_ge;

    assign w_shift = {r_rem, r_quo[MAG_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= CNT_BITS'(MAG_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_shift[DEN_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/piecewise_linear_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear map
// Maps a signed sample through one of the breakpoint tables held in a
// synchronous memory, by binary search and linear interpolation.
//
//   Channel  Direction  Handshake              Contents
//   in       input      i_in_valid/o_in_stall  load point or map sample
//   out      output     o_out_valid/i_out_stall mapped value and flags
//   cfg      input      i_cfg_valid/o_cfg_ready point count
//
// A load transaction writes the memory in the cycle it is accepted.
// A map searches in s steps (at most 3 for eight points), reads both
// interval ends, multiplies, then divides; the divider dominates, and a
// zero-width interval skips it. Each search step reads one memory entry.
// Reset is synchronous; the table memory is not cleared.
// A result waiting under stall holds the block only when the next is ready.
// ----------------------------------------------------------------------------
module piecewise_linear_map (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic                                i_table_select,
    input  logic [ple_pkg::PIDX_W-1:0]          i_point_index,
    input  logic signed [ple_pkg::COORD_W-1:0]  i_point_in,
    input  logic [ple_pkg::OUT_W-1:0]           i_point_out,
    input  logic signed [ple_pkg::COORD_W-1:0]  i_sample,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ple_pkg::CNT_W-1:0]           i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ple_pkg::OUT_W-1:0]           o_mapped,
    output logic                                o_table_used,
    output logic                                o_zero_interval,
    output logic                                o_clipped
);
    import ple_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_LO_RD,
        S_HI_RD,
        S_HI_CAP,
        S_MUL,
        S_DIV_ST,
        S_DIV,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_point_count;
    logic [ENTRY_W-1:0]        mem [DEPTH];
    logic [ENTRY_W-1:0]        r_rd_data;
    t_tbl                      r_tbl;
    logic signed [COORD_W-1:0] r_x;
    t_idx                      r_lo;
    t_idx                      r_hi;
    t_idx                      r_mid;
    logic signed [COORD_W-1:0] r_ilo;
    logic [OUT_W-1:0]          r_olo;
    logic signed [DIFF_W-1:0]  r_di;
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [OUT_W:0]     r_do;
    logic signed [NUM_W-1:0]   r_num;
    logic                      r_qneg;
    logic                      r_zero;
    logic signed [VAL_W-1:0]   r_val;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_mapped;
    logic                      r_table_used;
    logic                      r_zero_out;
    logic                      r_clipped;

    logic                      w_in_acc;
    logic                      w_we;
    t_addr                     w_waddr;
    t_addr                     w_raddr;
    t_idx                      w_raddr_idx;
    logic [IDX_W:0]            w_sum;
    t_idx                      w_mid;
    t_idx                      n_lo;
    t_idx                      n_hi;
    t_idx                      w_last;
    logic signed [COORD_W-1:0] w_mem_in;
    logic [OUT_W-1:0]          w_mem_out;
    logic [NUM_W-1:0]          w_num_abs;
    logic [DIFF_W-1:0]         w_di_abs;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [MAG_W-1:0]          w_quo;
    logic signed [VAL_W-1:0]   w_qext;
    logic signed [VAL_W-1:0]   w_oext;

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_we        = w_in_acc && !i_func && (int'(i_point_index) < MAX_POINTS);
    assign w_waddr     = mem_addr(table_of(i_table_select), IDX_W'(i_point_index));
    assign w_last      = last_index(r_point_count);

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[IDX_W:1];

    always_comb begin
        case (r_state)
            S_SRCH_RD: w_raddr_idx = w_mid;
            S_LO_RD:   w_raddr_idx = r_lo;
            default:   w_raddr_idx = r_hi;
        endcase
    end
    assign w_raddr = mem_addr(r_tbl, w_raddr_idx);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= {i_point_in, i_point_out};
        end
        r_rd_data <= mem[w_raddr];
    end

    assign w_mem_in  = $signed(r_rd_data[ENTRY_W-1:OUT_W]);
    assign w_mem_out = r_rd_data[OUT_W-1:0];

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_x < w_mem_in) begin
            n_hi = r_mid;
        end else begin
            n_lo = r_mid;
        end
    end

    assign w_num_abs   = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign w_di_abs    = r_di[DIFF_W-1] ? DIFF_W'(-r_di) : DIFF_W'(r_di);
    assign w_div_start = (r_state == S_DIV_ST);
    assign w_qext      = $signed({{(VAL_W - MAG_W){1'b0}}, w_quo});
    assign w_oext      = $signed({{(VAL_W - OUT_W){1'b0}}, r_olo});

    ple_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_num_abs[MAG_W-1:0]),
        .i_divisor  (w_di_abs[DEN_W-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_point_count <= POINT_COUNT_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_func) begin
                        r_tbl <= table_of(i_table_select);
                        r_x   <= i_sample;
                        r_lo  <= '0;
                        r_hi  <= w_last;
                        r_state <= adjacent('0, w_last) ? S_LO_RD : S_SRCH_RD;
                    end
                end
                S_SRCH_RD: begin
                    r_mid   <= w_mid;
                    r_state <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    r_lo    <= n_lo;
                    r_hi    <= n_hi;
                    r_state <= adjacent(n_lo, n_hi) ? S_LO_RD : S_SRCH_RD;
                end
                S_LO_RD: begin
                    r_state <= S_HI_RD;
                end
                S_HI_RD: begin
                    r_ilo   <= w_mem_in;
                    r_olo   <= w_mem_out;
                    r_state <= S_HI_CAP;
                end
                S_HI_CAP: begin
                    r_di    <= DIFF_W'(w_mem_in) - DIFF_W'(r_ilo);
                    r_dx    <= DIFF_W'(r_x) - DIFF_W'(r_ilo);
                    r_do    <= $signed({1'b0, w_mem_out}) - $signed({1'b0, r_olo});
                    r_zero  <= (w_mem_in == r_ilo);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num <= r_do * r_dx;
                    if (r_zero) begin
                        r_val   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV_ST;
                    end
                end
                S_DIV_ST: begin
                    r_qneg  <= r_num[NUM_W-1] ^ r_di[DIFF_W-1];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_val   <= r_qneg ? (w_oext - w_qext) : (w_oext + w_qext);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_table_used <= r_tbl[0];
                        r_zero_out   <= r_zero;
                        if (r_val < 0) begin
                            r_mapped  <= '0;
                            r_clipped <= 1'b1;
                        end else if (r_val > VAL_W'(255)) begin
                            r_mapped  <= '1;
                            r_clipped <= 1'b1;
                        end else begin
                            r_mapped  <= r_val[OUT_W-1:0];
                            r_clipped <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mapped        = r_mapped;
    assign o_table_used    = r_table_used;
    assign o_zero_interval = r_zero_out;
    assign o_clipped       = r_clipped;

endmodule

/* rtl/core/ple_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear map checker
// Port-level assertions on the map block, attached by a bind statement.
// ----------------------------------------------------------------------------
module ple_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_func,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [ple_pkg::OUT_W-1:0]          o_mapped,
    input logic                               o_zero_interval,
    input logic                               o_clipped
);
    import ple_pkg::*;

    // A result held under stall must stay presented.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    // A zero-width interval always reports zero and is never clipped.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_interval |-> (o_mapped == '0) && !o_clipped)
        else $error("zero interval result is not zero");

    // A clipped value sits on one of the two rails.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> (o_mapped == '0) || (o_mapped == '1))
        else $error("clipped result is off the rails");

    // A map transaction occupies the block on the following cycle.
    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_func |=> o_in_stall)
        else $error("map transaction did not occupy the block");

endmodule

bind piecewise_linear_map ple_checker u_ple_checker (.*);
